@@ hdl/ralp_pkg.sv @@
// Shared types and constants for the router advertisement lifetime parser.
package ralp_pkg;

  localparam int unsigned MaxPacketBytes = 1460;
  localparam int unsigned PosW           = 11;
  localparam int unsigned LifeW          = 32;
  localparam int unsigned CandW          = 42;
  localparam int unsigned RunW           = 32;
  localparam int unsigned DefW           = 22;
  localparam int unsigned MsW            = 31;

  localparam logic [PosW-1:0] MaxPos         = PosW'(MaxPacketBytes);
  localparam logic [PosW-1:0] HeaderBytes    = PosW'(16);
  localparam logic [PosW-1:0] PrefixOptBytes = PosW'(32);
  localparam logic [7:0]      RaType         = 8'd134;
  localparam logic [7:0]      OptPrefix      = 8'd3;
  localparam logic [7:0]      OptRoute       = 8'd24;
  localparam logic [7:0]      RouteMaxUnits  = 8'd3;
  localparam logic [7:0]      PrefixLenMax   = 8'd128;
  localparam logic [MsW-1:0]  Max31          = '1;
  localparam logic [DefW-1:0] DefTimeoutRst  = DefW'(3600);
  localparam logic [MsW-1:0]  MinIntervalRst = MsW'(240000);

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusNotRa     = 2'd1,
    StatusMalformed = 2'd2
  } status_e;

  typedef enum logic {
    CfgDefaultTimeout = 1'b0,
    CfgMinInterval    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_e        status;
    logic [MsW-1:0] timeout_ms;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic             fin;
    status_e          status;
    logic             cand_a_v;
    logic [CandW-1:0] cand_a;
    logic             cand_b_v;
    logic [CandW-1:0] cand_b;
  } ralp_ev_t;

endpackage

@@ hdl/ralp_parse.sv @@
// Byte parser: header checks, option walk and lifetime candidates scaled to 800 per second of lifetime.
module ralp_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  ralp_pkg::in_item_t item_i,
  output ralp_pkg::ralp_ev_t ev_o
);

  logic [ralp_pkg::PosW-1:0]  pos_q, pos_d;
  logic                       hdr_bad_q, hdr_bad_d;
  logic [7:0]                 hword_q, hword_d;
  logic [7:0]                 opt_type_q, opt_type_d;
  logic [ralp_pkg::PosW-1:0]  opt_len_q, opt_len_d;
  logic [ralp_pkg::PosW-1:0]  opt_pos_q, opt_pos_d;
  logic                       malf_q, malf_d;
  logic [ralp_pkg::LifeW-1:0] life_a_q, life_a_d;
  logic [ralp_pkg::LifeW-1:0] life_b_q, life_b_d;
  logic                       stop_q, stop_d;
  logic                       err_q, err_d;

  logic [7:0]                 d;
  logic [ralp_pkg::PosW-1:0]  len_new;
  logic [8:0]                 plen_sum;
  logic                       cand_a_v, cand_b_v;
  logic [ralp_pkg::LifeW-1:0] sec_a, sec_b;
  logic [ralp_pkg::CandW-1:0] wide_a, wide_b;

  always_comb begin
    d         = item_i.data_byte;
    len_new   = {d, 3'b000};
    plen_sum  = {1'b0, d} + 9'd127;
    pos_d     = pos_q;
    hdr_bad_d = hdr_bad_q;
    hword_d   = hword_q;
    opt_type_d = opt_type_q;
    opt_len_d = opt_len_q;
    opt_pos_d = opt_pos_q;
    malf_d    = malf_q;
    life_a_d  = life_a_q;
    life_b_d  = life_b_q;
    stop_d    = stop_q;
    err_d     = err_q;
    cand_a_v  = 1'b0;
    cand_b_v  = 1'b0;
    sec_a     = '0;
    sec_b     = '0;

    if (pos_q < ralp_pkg::MaxPos) begin
      if (pos_q == ralp_pkg::PosW'(0)) begin
        if (d != ralp_pkg::RaType) hdr_bad_d = 1'b1;
      end else if (pos_q == ralp_pkg::PosW'(1)) begin
        if (d != 8'd0) hdr_bad_d = 1'b1;
      end else if (pos_q == ralp_pkg::PosW'(6)) begin
        hword_d = d;
      end else if (pos_q == ralp_pkg::PosW'(7)) begin
        cand_a_v = 1'b1;
        sec_a    = ralp_pkg::LifeW'({hword_q, d});
      end else if (pos_q >= ralp_pkg::HeaderBytes && !hdr_bad_q && !stop_q && !err_q) begin
        if (opt_pos_q == ralp_pkg::PosW'(1) && d == 8'd0) begin
          stop_d = 1'b1;
        end else begin
          if (opt_pos_q == ralp_pkg::PosW'(0)) begin
            opt_type_d = d;
            malf_d     = 1'b0;
            life_a_d   = '0;
            life_b_d   = '0;
          end else if (opt_pos_q == ralp_pkg::PosW'(1)) begin
            opt_len_d = len_new;
            if (opt_type_q == ralp_pkg::OptPrefix && len_new < ralp_pkg::PrefixOptBytes) begin
              malf_d = 1'b1;
            end
            if (opt_type_q == ralp_pkg::OptRoute && d > ralp_pkg::RouteMaxUnits) begin
              malf_d = 1'b1;
            end
          end else if (opt_pos_q == ralp_pkg::PosW'(2)) begin
            if (opt_type_q == ralp_pkg::OptRoute &&
                (d > ralp_pkg::PrefixLenMax || opt_len_q[10:3] < {5'd0, plen_sum[8:6]})) begin
              malf_d = 1'b1;
            end
          end else if (opt_pos_q >= ralp_pkg::PosW'(4) && opt_pos_q <= ralp_pkg::PosW'(7)) begin
            life_a_d = {life_a_q[23:0], d};
          end else if (opt_pos_q >= ralp_pkg::PosW'(8) && opt_pos_q <= ralp_pkg::PosW'(11)) begin
            life_b_d = {life_b_q[23:0], d};
          end

          if (opt_pos_q != ralp_pkg::PosW'(0) && opt_pos_q + ralp_pkg::PosW'(1) == opt_len_d) begin
            if (opt_type_d == ralp_pkg::OptPrefix || opt_type_d == ralp_pkg::OptRoute) begin
              if (malf_d) begin
                err_d = 1'b1;
              end else begin
                cand_a_v = 1'b1;
                sec_a    = life_a_d;
                cand_b_v = (opt_type_d == ralp_pkg::OptPrefix);
                sec_b    = life_b_d;
              end
            end
            opt_pos_d = '0;
          end else begin
            opt_pos_d = opt_pos_q + ralp_pkg::PosW'(1);
          end
        end
      end
      pos_d = pos_q + ralp_pkg::PosW'(1);
    end

    ev_o.start    = (pos_q == ralp_pkg::PosW'(0));
    ev_o.fin      = item_i.last_byte;
    if (pos_d < ralp_pkg::HeaderBytes || hdr_bad_d) begin
      ev_o.status = ralp_pkg::StatusNotRa;
    end else if (err_d) begin
      ev_o.status = ralp_pkg::StatusMalformed;
    end else begin
      ev_o.status = ralp_pkg::StatusOk;
    end

    wide_a = ralp_pkg::CandW'(sec_a);
    wide_b = ralp_pkg::CandW'(sec_b);
    ev_o.cand_a_v = cand_a_v;
    ev_o.cand_a   = (wide_a << 9) + (wide_a << 8) + (wide_a << 5);
    ev_o.cand_b_v = cand_b_v;
    ev_o.cand_b   = (wide_b << 9) + (wide_b << 8) + (wide_b << 5);

    if (item_i.last_byte) begin
      pos_d      = '0;
      hdr_bad_d  = 1'b0;
      hword_d    = '0;
      opt_type_d = '0;
      opt_len_d  = '0;
      opt_pos_d  = '0;
      malf_d     = 1'b0;
      life_a_d   = '0;
      life_b_d   = '0;
      stop_d     = 1'b0;
      err_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      hdr_bad_q  <= 1'b0;
      hword_q    <= '0;
      opt_type_q <= '0;
      opt_len_q  <= '0;
      opt_pos_q  <= '0;
      malf_q     <= 1'b0;
      life_a_q   <= '0;
      life_b_q   <= '0;
      stop_q     <= 1'b0;
      err_q      <= 1'b0;
    end else if (accept_i) begin
      pos_q      <= pos_d;
      hdr_bad_q  <= hdr_bad_d;
      hword_q    <= hword_d;
      opt_type_q <= opt_type_d;
      opt_len_q  <= opt_len_d;
      opt_pos_q  <= opt_pos_d;
      malf_q     <= malf_d;
      life_a_q   <= life_a_d;
      life_b_q   <= life_b_d;
      stop_q     <= stop_d;
      err_q      <= err_d;
    end
  end

endmodule

@@ hdl/router_advert_lifetime_parser_top.sv @@
// Top level of the router advertisement lifetime parser.
// One byte is taken per cycle while the output is not stalled, back to back, with no gaps between packets.
// After the transfer of the last byte, a result passes the s1 and s2 registers and then reaches the output register.
// The whole pipeline holds while a result waits at the output and out_ready_i is low.
// Reset clears all control state and loads the register defaults of 3600 s and 240000 ms.
module router_advert_lifetime_parser_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  ralp_pkg::in_item_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output ralp_pkg::out_item_t       out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [ralp_pkg::MsW-1:0]  cfg_data_i
);

  logic                        en, accept;
  ralp_pkg::ralp_ev_t          ev, s1_q;
  logic                        s1_v_q;
  logic [ralp_pkg::DefW-1:0]   def_s_q;
  logic [ralp_pkg::MsW-1:0]    min_ms_q;
  logic [ralp_pkg::RunW-1:0]   def_ms_q, def32;
  logic [ralp_pkg::RunW-1:0]   run_q, base;
  logic [ralp_pkg::CandW-1:0]  m1, m2;
  logic                        s2_v_q;
  ralp_pkg::status_e           s2_status_q;
  logic [ralp_pkg::RunW-1:0]   s2_min_q;
  logic [ralp_pkg::MsW-1:0]    sat, floored;
  logic                        out_valid_q;
  ralp_pkg::out_item_t         out_q, out_d;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign accept      = in_valid_i && en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  ralp_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .ev_o     (ev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_s_q  <= ralp_pkg::DefTimeoutRst;
      min_ms_q <= ralp_pkg::MinIntervalRst;
    end else if (cfg_valid_i) begin
      unique case (ralp_pkg::cfg_idx_e'(cfg_index_i))
        ralp_pkg::CfgDefaultTimeout: def_s_q  <= cfg_data_i[ralp_pkg::DefW-1:0];
        ralp_pkg::CfgMinInterval:    min_ms_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    def32 = ralp_pkg::RunW'(def_s_q);
    base  = s1_q.start ? def_ms_q : run_q;
    m1    = ralp_pkg::CandW'(base);
    if (s1_q.cand_a_v && s1_q.cand_a != '0 && s1_q.cand_a < m1) m1 = s1_q.cand_a;
    m2    = m1;
    if (s1_q.cand_b_v && s1_q.cand_b != '0 && s1_q.cand_b < m1) m2 = s1_q.cand_b;
  end

  always_comb begin
    sat     = (s2_min_q > ralp_pkg::RunW'(ralp_pkg::Max31)) ? ralp_pkg::Max31
                                                          : s2_min_q[ralp_pkg::MsW-1:0];
    floored = (sat < min_ms_q) ? min_ms_q : sat;
    out_d.status     = s2_status_q;
    out_d.timeout_ms = (s2_status_q == ralp_pkg::StatusOk) ? floored : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      run_q       <= '0;
    end else if (en) begin
      s1_v_q      <= accept;
      s2_v_q      <= s1_v_q && s1_q.fin;
      out_valid_q <= s2_v_q;
      if (s1_v_q) run_q <= m2[ralp_pkg::RunW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    def_ms_q <= (def32 << 10) - (def32 << 4) - (def32 << 3);
    if (en) begin
      s1_q        <= ev;
      s2_status_q <= s1_q.status;
      s2_min_q    <= m2[ralp_pkg::RunW-1:0];
      out_q       <= out_d;
    end
  end

endmodule

@@ hdl/ralp_checker.sv @@
// Port-level checker for the router advertisement lifetime parser and its bind.
module ralp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input ralp_pkg::in_item_t        in_data_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input ralp_pkg::out_item_t       out_data_o,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic                      cfg_index_i,
  input logic [ralp_pkg::MsW-1:0]  cfg_data_i
);

  logic [2:0]               pend_q;
  logic [ralp_pkg::MsW-1:0] min_shadow_q;
  logic                     in_last_xfer, out_xfer;

  assign in_last_xfer = in_valid_i && in_ready_o && in_data_i.last_byte;
  assign out_xfer     = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      min_shadow_q <= ralp_pkg::MinIntervalRst;
    end else begin
      pend_q <= pend_q + {2'b00, in_last_xfer} - {2'b00, out_xfer};
      if (cfg_valid_i && cfg_ready_o &&
          ralp_pkg::cfg_idx_e'(cfg_index_i) == ralp_pkg::CfgMinInterval) begin
        min_shadow_q <= cfg_data_i;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Result changed or dropped while stalled.");

  a_out_has_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("Result shown without a pending packet end.");

  a_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ralp_pkg::StatusOk
      |-> out_data_o.timeout_ms >= min_shadow_q)
    else $error("Successful timeout below the minimum interval.");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ralp_pkg::StatusOk
      |-> out_data_o.timeout_ms == '0 &&
          (out_data_o.status == ralp_pkg::StatusNotRa ||
           out_data_o.status == ralp_pkg::StatusMalformed))
    else $error("Failed result carries a timeout or an unknown status.");

endmodule

bind router_advert_lifetime_parser_top ralp_checker u_ralp_checker (.*);
